### hdl/fpss_pkg.sv
// shared types and constants of the flash page split sequencer
`default_nettype none
package fpss_pkg;

    localparam int ADDR_W = 24;
    localparam int LEN_W  = 13;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic CMD_READ_DATA    = 1'b0;
    localparam logic CMD_PAGE_PROGRAM = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

### hdl/flash_page_split_sequencer_top.sv
// top level of the flash page split sequencer
//
// Splits one flash access request into command segments. A read request
// gives one read-data segment; a write request gives page-program segments
// that never cross a PAGE_SIZE boundary (PAGE_SIZE a power of two), at most
// MAX_LENGTH/PAGE_SIZE+1 of them. Lengths above MAX_LENGTH are saturated,
// zero-length requests give no output. An accepted request is queued
// (two entries); its first segment appears once the queue entry is written,
// the segment generator has loaded it and the output register is set. The
// generator then emits one segment per cycle while m_tready is high, and it
// loads the next request from the queue only after the last segment of the
// previous one. Intake keeps taking requests while the queue has room.
`default_nettype none
module flash_page_split_sequencer_top #(
    parameter int PAGE_SIZE  = 256,
    parameter int MAX_LENGTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // start_address, byte_count, zero fill
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // segment_address, segment_length, zero fill
    output logic             m_tuser,   // command
    output logic             m_tlast
);

    fpss_pkg::q_stat_t q_stat;
    fpss_pkg::req_t    push_req;
    fpss_pkg::req_t    pop_req;
    logic              push;
    logic              pop;

    fpss_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_req (push_req)
    );

    fpss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .pop_req  (pop_req),
        .q_stat   (q_stat)
    );

    fpss_back #(
        .PAGE_SIZE(PAGE_SIZE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_req  (pop_req),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### hdl/fpss_front.sv
// request intake: length saturation and zero-length filtering
`default_nettype none
module fpss_front #(
    parameter int MAX_LENGTH = 4096
) (
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [39:0]                s_tdata,
    input  wire logic                       s_tuser,
    input  wire fpss_pkg::q_stat_t          q_stat,
    output logic                            push,
    output fpss_pkg::req_t                  push_req
);

    localparam int CMP_W = 15;

    logic [fpss_pkg::LEN_W-1:0] count;
    logic                       over;

    assign count    = s_tdata[fpss_pkg::ADDR_W +: fpss_pkg::LEN_W];
    assign over     = {{(CMP_W-fpss_pkg::LEN_W){1'b0}}, count} > CMP_W'(MAX_LENGTH);
    assign s_tready = !q_stat.full;

    always_comb begin
        push_req.op   = s_tuser;
        push_req.addr = s_tdata[fpss_pkg::ADDR_W-1:0];
        push_req.len  = over ? fpss_pkg::LEN_W'(MAX_LENGTH) : count;
    end

    // zero-length requests are taken and dropped
    assign push = s_tvalid && !q_stat.full && (count != '0);

endmodule
`default_nettype wire

### hdl/fpss_queue.sv
// short request queue between intake and segment generator
`default_nettype none
module fpss_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire fpss_pkg::req_t      push_req,
    input  wire logic                pop,
    output fpss_pkg::req_t           pop_req,
    output fpss_pkg::q_stat_t        q_stat
);

    fpss_pkg::req_t                 mem [fpss_pkg::Q_DEPTH];
    logic [fpss_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [fpss_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [fpss_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign q_stat.full  = (cnt_reg == fpss_pkg::Q_CNT_W'(fpss_pkg::Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_req      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule
`default_nettype wire

### hdl/fpss_back.sv
// segment generator: walks one request and emits its segments
`default_nettype none
module fpss_back #(
    parameter int PAGE_SIZE = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fpss_pkg::q_stat_t   q_stat,
    input  wire fpss_pkg::req_t      pop_req,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int PB = $clog2(PAGE_SIZE);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic                            op_reg, op_next;
    logic [fpss_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [fpss_pkg::LEN_W-1:0]      rem_reg, rem_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_cmd_reg, out_cmd_next;
    logic [fpss_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [fpss_pkg::LEN_W-1:0]      out_len_reg, out_len_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic [fpss_pkg::LEN_W-1:0]      room;
    logic [fpss_pkg::LEN_W-1:0]      seg_len;

    assign out_free = !out_valid_reg || m_tready;
    assign room     = fpss_pkg::LEN_W'(PAGE_SIZE)
                    - {{(fpss_pkg::LEN_W-PB){1'b0}}, addr_reg[PB-1:0]};
    assign seg_len  = (op_reg == fpss_pkg::OP_WRITE && room < rem_reg) ? room : rem_reg;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cmd_next   = out_cmd_reg;
        out_addr_next  = out_addr_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    op_next    = pop_req.op;
                    addr_next  = pop_req.addr;
                    rem_next   = pop_req.len;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = (op_reg == fpss_pkg::OP_WRITE) ?
                                     fpss_pkg::CMD_PAGE_PROGRAM : fpss_pkg::CMD_READ_DATA;
                    out_addr_next  = addr_reg;
                    out_len_next   = seg_len;
                    out_last_next  = (seg_len == rem_reg);
                    addr_next      = addr_reg + fpss_pkg::ADDR_W'(seg_len);
                    rem_next       = rem_reg - seg_len;
                    if (seg_len == rem_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        rem_reg      <= rem_next;
        out_cmd_reg  <= out_cmd_next;
        out_addr_reg <= out_addr_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(40-fpss_pkg::ADDR_W-fpss_pkg::LEN_W){1'b0}}, out_len_reg, out_addr_reg};

endmodule
`default_nettype wire

### hdl/fpss_checker.sv
// port-level checks of the flash page split sequencer and their bind
`default_nettype none
module fpss_checker #(
    parameter int PAGE_SIZE = 256
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    localparam int PB = $clog2(PAGE_SIZE);

    logic [fpss_pkg::LEN_W-1:0] seg_len;
    logic [fpss_pkg::LEN_W-1:0] seg_end;

    assign seg_len = m_tdata[fpss_pkg::ADDR_W +: fpss_pkg::LEN_W];
    assign seg_end = {{(fpss_pkg::LEN_W-PB){1'b0}}, m_tdata[PB-1:0]} + seg_len;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_read_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpss_pkg::CMD_READ_DATA |-> m_tlast)
        else $error("read segment not marked last");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpss_pkg::CMD_PAGE_PROGRAM
        |-> seg_len != '0 && seg_len <= fpss_pkg::LEN_W'(PAGE_SIZE))
        else $error("page program length out of range");

    a_page_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpss_pkg::CMD_PAGE_PROGRAM && !m_tlast
        |-> seg_end == fpss_pkg::LEN_W'(PAGE_SIZE))
        else $error("inner page program segment does not end on a page boundary");

endmodule

bind flash_page_split_sequencer_top fpss_checker #(
    .PAGE_SIZE(PAGE_SIZE)
) u_fpss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
